// ----- sv/bfns_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfns_pkg: shared definitions for the bit map find-next-set block
// Field widths, opcodes, register indexes and parameter defaults.
// ----------------------------------------------------------------------------
package bfns_pkg;

   // payload field widths
   localparam int OPCODE_W    = 3;
   localparam int BIT_INDEX_W = 12;

   // configuration port
   localparam int SIZE_W      = 13;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 13;

   localparam logic [CSR_INDEX_W-1:0] CSR_SIZE_IN_USE = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FILL_VALUE  = 1'd1;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 13'd4096;

   // opcodes
   localparam logic [OPCODE_W-1:0] OP_TEST      = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_SET       = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_CLEAR     = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_FIND_UP   = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_FIND_DOWN = 3'd4;
   localparam logic [OPCODE_W-1:0] OP_FILL      = 3'd5;

   // parameter defaults (both must be powers of two)
   localparam int DEF_MAX_BITS  = 4096;
   localparam int DEF_WORD_BITS = 64;

endpackage
`default_nettype wire

// ----- sv/bfns_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfns request / response channels
// Valid-ready channels carrying one request beat and one response beat.
// ----------------------------------------------------------------------------
interface bfns_req_if;
   import bfns_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [OPCODE_W-1:0]    opcode;
   logic [BIT_INDEX_W-1:0] bit_index;

   modport source (output valid, output opcode, output bit_index, input ready);
   modport sink   (input valid, input opcode, input bit_index, output ready);
endinterface

interface bfns_rsp_if;
   import bfns_pkg::*;

   logic                   valid;
   logic                   ready;
   logic                   bit_value;
   logic                   found;
   logic [BIT_INDEX_W-1:0] found_index;
   logic                   index_valid;

   modport source (output valid, output bit_value, output found,
                   output found_index, output index_valid, input ready);
   modport sink   (input valid, input bit_value, input found,
                   input found_index, input index_valid, output ready);
endinterface
`default_nettype wire

// ----- sv/bitmap_find_next_set.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_find_next_set: bit map store with test, set, clear, find and fill
// Word-organized bit map in one single-port-write memory, walked by a small
// sequencer and one shared word scanner.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one request beat (opcode, bit_index); rsp_ch returns
//   exactly one response beat per request, in order. csr_we/csr_index/
//   csr_wdata write size_in_use (index 0) and fill_value (index 1); write
//   them only while no request is outstanding.
//   States from request beat to the output register, W = MAX_BITS/WORD_BITS:
//     test, set, clear: access, then done; out-of-range index or unused
//     opcode: done; find up / find down: scan over 1 to W words, one word
//     per cycle through the memory read port and the scanner, then done
//     fill: all W words, one word written per cycle, then done
//   The block takes one request at a time; req_ch.ready is high only while
//   the sequencer is idle.
//   Reset: after reset is released the sequencer clears the memory, one word
//   per cycle, with req_ch.ready low.
//   Stall: a response waits in the output register while rsp_ch.ready is
//   low; the next request is still taken, and its result waits in the
//   sequencer until the output register frees up.
// ----------------------------------------------------------------------------
module bitmap_find_next_set #(
   parameter int MAX_BITS  = bfns_pkg::DEF_MAX_BITS,
   parameter int WORD_BITS = bfns_pkg::DEF_WORD_BITS
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   bfns_req_if.sink                            req_ch,
   bfns_rsp_if.source                          rsp_ch,
   input  wire logic                           csr_we,
   input  wire logic [bfns_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [bfns_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import bfns_pkg::*;

   localparam int NUM_WORDS = MAX_BITS / WORD_BITS;
   localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int WB_LG     = $clog2(WORD_BITS);
   localparam int ESZ_W     = $clog2(MAX_BITS + 1);
   localparam int CMP_W     = (ESZ_W > SIZE_W) ? ESZ_W : SIZE_W;

   localparam logic [WORD_BITS-1:0] ONES    = '1;
   localparam logic [WORD_BITS-1:0] ONE_BIT = WORD_BITS'(1);
   localparam logic [AW-1:0]        LAST_W  = AW'(NUM_WORDS - 1);
   localparam logic [AW-1:0]        W_STEP  = AW'(1);
   localparam logic [CMP_W-1:0]     MAX_SZ  = CMP_W'(MAX_BITS);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_ACCESS = 5'b00010,
      ST_SCAN   = 5'b00100,
      ST_FILL   = 5'b01000,
      ST_DONE   = 5'b10000
   } state_type;

   // registers
   state_type               state_ff, state_in;
   logic [OPCODE_W-1:0]     op_ff, op_in;
   logic [WB_LG-1:0]        off_ff, off_in;
   logic [AW-1:0]           start_w_ff, start_w_in;
   logic [AW-1:0]           end_w_ff, end_w_in;
   logic [AW-1:0]           rd_ptr_ff, rd_ptr_in;
   logic [AW-1:0]           eval_ptr_ff, eval_ptr_in;
   logic [WORD_BITS-1:0]    first_mask_ff, first_mask_in;
   logic [WORD_BITS-1:0]    last_mask_ff, last_mask_in;
   logic                    fill_val_ff, fill_val_in;
   logic [CMP_W-1:0]        fill_full_ff, fill_full_in;
   logic [WB_LG-1:0]        fill_part_ff, fill_part_in;
   logic                    clr_ff, clr_in;
   logic                    res_bit_ff, res_bit_in;
   logic                    res_found_ff, res_found_in;
   logic [BIT_INDEX_W-1:0]  res_idx_ff, res_idx_in;
   logic                    res_ivalid_ff, res_ivalid_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_bit_ff, rsp_bit_in;
   logic                    rsp_found_ff, rsp_found_in;
   logic [BIT_INDEX_W-1:0]  rsp_idx_ff, rsp_idx_in;
   logic                    rsp_ivalid_ff, rsp_ivalid_in;
   logic [SIZE_W-1:0]       size_ff, size_in;
   logic                    fillcfg_ff, fillcfg_in;
   logic [WORD_BITS-1:0]    rd_data_ff;

   // memory
   logic [WORD_BITS-1:0]    mem [NUM_WORDS];
   logic                    wr_en;
   logic [AW-1:0]           wr_addr;
   logic [WORD_BITS-1:0]    wr_data;
   logic [AW-1:0]           rd_addr;

   // request decode
   logic                    req_beat;
   logic [CMP_W-1:0]        n_ext;
   logic [CMP_W-1:0]        size_ext;
   logic [CMP_W-1:0]        eff_size;
   logic [CMP_W-1:0]        eff_m1;
   logic                    n_valid;
   logic [AW-1:0]           n_word;
   logic [WB_LG-1:0]        n_off;
   logic [AW-1:0]           last_w;
   logic [WB_LG-1:0]        lim_off;

   // scan and fill helpers
   logic                    scan_down;
   logic [WORD_BITS-1:0]    scan_mask;
   logic                    scan_hit;
   logic [WB_LG-1:0]        scan_pos;
   logic [CMP_W-1:0]        scan_idx;
   logic [CMP_W-1:0]        fill_k;
   logic [WORD_BITS-1:0]    fill_word;
   logic                    cur_bit;

   assign req_beat = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE);

   // effective size and index split
   assign n_ext    = CMP_W'(req_ch.bit_index);
   assign size_ext = CMP_W'(size_ff);
   assign eff_size = (size_ext > MAX_SZ) ? MAX_SZ : size_ext;
   assign eff_m1   = eff_size - CMP_W'(1);
   assign n_valid  = n_ext < eff_size;
   assign n_word   = AW'(n_ext >> WB_LG);
   assign n_off    = n_ext[WB_LG-1:0];
   assign last_w   = AW'(eff_m1 >> WB_LG);
   assign lim_off  = eff_m1[WB_LG-1:0];

   // scan window masks for the word under evaluation
   assign scan_down = (op_ff == OP_FIND_DOWN);
   always_comb begin
      scan_mask = ONES;
      if (eval_ptr_ff == start_w_ff) begin
         scan_mask = scan_mask & first_mask_ff;
      end
      if (eval_ptr_ff == end_w_ff) begin
         scan_mask = scan_mask & last_mask_ff;
      end
   end

   bfns_scan #(
      .WORD_BITS (WORD_BITS)
   ) u_scan (
      .word    (rd_data_ff & scan_mask),
      .reverse (scan_down),
      .hit     (scan_hit),
      .pos     (scan_pos)
   );

   assign scan_idx = (CMP_W'(eval_ptr_ff) << WB_LG) | CMP_W'(scan_pos);

   // fill pattern for the word at the write pointer
   assign fill_k = CMP_W'(rd_ptr_ff);
   always_comb begin
      if (!fill_val_ff) begin
         fill_word = '0;
      end else if (fill_k < fill_full_ff) begin
         fill_word = ONES;
      end else if (fill_k == fill_full_ff) begin
         fill_word = ~(ONES << fill_part_ff);
      end else begin
         fill_word = '0;
      end
   end

   assign cur_bit = rd_data_ff[off_ff];

   // sequencer
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      off_in        = off_ff;
      start_w_in    = start_w_ff;
      end_w_in      = end_w_ff;
      rd_ptr_in     = rd_ptr_ff;
      eval_ptr_in   = eval_ptr_ff;
      first_mask_in = first_mask_ff;
      last_mask_in  = last_mask_ff;
      fill_val_in   = fill_val_ff;
      fill_full_in  = fill_full_ff;
      fill_part_in  = fill_part_ff;
      clr_in        = clr_ff;
      res_bit_in    = res_bit_ff;
      res_found_in  = res_found_ff;
      res_idx_in    = res_idx_ff;
      res_ivalid_in = res_ivalid_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_bit_in    = rsp_bit_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_ivalid_in = rsp_ivalid_ff;
      size_in       = size_ff;
      fillcfg_in    = fillcfg_ff;
      wr_en         = 1'b0;
      wr_addr       = rd_ptr_ff;
      wr_data       = fill_word;
      rd_addr       = rd_ptr_ff;

      // configuration writes
      if (csr_we) begin
         case (csr_index)
            CSR_SIZE_IN_USE: size_in    = csr_wdata[SIZE_W-1:0];
            CSR_FILL_VALUE:  fillcfg_in = csr_wdata[0];
            default:         ;
         endcase
      end

      // response beat taken
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            rd_addr = n_word;
            if (req_beat) begin
               op_in         = req_ch.opcode;
               off_in        = n_off;
               start_w_in    = n_word;
               eval_ptr_in   = n_word;
               res_bit_in    = 1'b0;
               res_found_in  = 1'b0;
               res_idx_in    = '0;
               res_ivalid_in = n_valid;
               state_in      = ST_DONE;
               case (req_ch.opcode)
                  OP_TEST, OP_SET, OP_CLEAR: begin
                     if (n_valid) begin
                        state_in = ST_ACCESS;
                     end
                  end
                  OP_FIND_UP: begin
                     first_mask_in = ONES << n_off;
                     last_mask_in  = ~((ONES << lim_off) << 1);
                     end_w_in      = last_w;
                     rd_ptr_in     = n_word + ((n_word != last_w) ? W_STEP : '0);
                     if (n_valid) begin
                        state_in = ST_SCAN;
                     end
                  end
                  OP_FIND_DOWN: begin
                     first_mask_in = ~((ONES << n_off) << 1);
                     last_mask_in  = ONES;
                     end_w_in      = '0;
                     rd_ptr_in     = n_word - ((n_word != '0) ? W_STEP : '0);
                     if (n_valid) begin
                        state_in = ST_SCAN;
                     end
                  end
                  OP_FILL: begin
                     rd_ptr_in    = '0;
                     fill_val_in  = fillcfg_ff;
                     fill_full_in = eff_size >> WB_LG;
                     fill_part_in = eff_size[WB_LG-1:0];
                     state_in     = ST_FILL;
                  end
                  default: ;
               endcase
            end
         end

         // single-word access: read for test, read-modify-write for set and clear
         ST_ACCESS: begin
            wr_addr = start_w_ff;
            case (op_ff)
               OP_TEST: res_bit_in = cur_bit;
               OP_SET: begin
                  wr_en   = 1'b1;
                  wr_data = rd_data_ff | (ONE_BIT << off_ff);
               end
               OP_CLEAR: begin
                  wr_en   = 1'b1;
                  wr_data = rd_data_ff & ~(ONE_BIT << off_ff);
               end
               default: ;
            endcase
            state_in = ST_DONE;
         end

         // one word issued and one word evaluated per cycle
         ST_SCAN: begin
            eval_ptr_in = rd_ptr_ff;
            if (rd_ptr_ff != end_w_ff) begin
               rd_ptr_in = scan_down ? (rd_ptr_ff - W_STEP) : (rd_ptr_ff + W_STEP);
            end
            if (scan_hit) begin
               res_found_in = 1'b1;
               res_idx_in   = scan_idx[BIT_INDEX_W-1:0];
               state_in     = ST_DONE;
            end else if (eval_ptr_ff == end_w_ff) begin
               state_in = ST_DONE;
            end
         end

         // fill or post-reset clear, one word per cycle
         ST_FILL: begin
            wr_en = 1'b1;
            if (rd_ptr_ff == LAST_W) begin
               clr_in   = 1'b0;
               state_in = clr_ff ? ST_IDLE : ST_DONE;
            end else begin
               rd_ptr_in = rd_ptr_ff + W_STEP;
            end
         end

         // hand the result to the output register
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_bit_in    = res_bit_ff;
               rsp_found_in  = res_found_ff;
               rsp_idx_in    = res_idx_ff;
               rsp_ivalid_in = res_ivalid_ff;
               state_in      = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FILL;
         rd_ptr_ff    <= '0;
         fill_val_ff  <= 1'b0;
         fill_full_ff <= '0;
         fill_part_ff <= '0;
         clr_ff       <= 1'b1;
         rsp_valid_ff <= 1'b0;
         size_ff      <= SIZE_RESET;
         fillcfg_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_ptr_ff    <= rd_ptr_in;
         fill_val_ff  <= fill_val_in;
         fill_full_ff <= fill_full_in;
         fill_part_ff <= fill_part_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         size_ff      <= size_in;
         fillcfg_ff   <= fillcfg_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      off_ff        <= off_in;
      start_w_ff    <= start_w_in;
      end_w_ff      <= end_w_in;
      eval_ptr_ff   <= eval_ptr_in;
      first_mask_ff <= first_mask_in;
      last_mask_ff  <= last_mask_in;
      res_bit_ff    <= res_bit_in;
      res_found_ff  <= res_found_in;
      res_idx_ff    <= res_idx_in;
      res_ivalid_ff <= res_ivalid_in;
      rsp_bit_ff    <= rsp_bit_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_ivalid_ff <= rsp_ivalid_in;
   end

   // word memory, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // response channel
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.bit_value   = rsp_bit_ff;
   assign rsp_ch.found       = rsp_found_ff;
   assign rsp_ch.found_index = rsp_idx_ff;
   assign rsp_ch.index_valid = rsp_ivalid_ff;

   // a hit is only reported for an in-range index and never with a bit value
   a_found_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_found_ff) |-> (rsp_ivalid_ff && !rsp_bit_ff))
      else $error("found response with inconsistent fields");

   // a request beat always leaves idle
   a_busy_after_beat: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> (state_ff != ST_IDLE))
      else $error("sequencer idle right after a request beat");

   // the post-reset clear never produces a response
   a_clear_silent: assert property (@(posedge clock) disable iff (reset)
      clr_ff |-> (!rsp_valid_ff && state_ff == ST_FILL))
      else $error("response or other state during post-reset clear");

   // upward scan stays between start word and last valid word
   a_scan_up_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && op_ff == OP_FIND_UP)
         |-> (eval_ptr_ff >= start_w_ff && eval_ptr_ff <= end_w_ff))
      else $error("upward scan outside its window");

   // downward scan never passes the start word
   a_scan_down_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && op_ff == OP_FIND_DOWN) |-> (eval_ptr_ff <= start_w_ff))
      else $error("downward scan above its start word");

endmodule
`default_nettype wire

// ----- sv/bfns_scan.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfns_scan: shared word scanner
// Finds the lowest set bit of a word, or the highest one when reverse is set.
// ----------------------------------------------------------------------------
module bfns_scan #(
   parameter int WORD_BITS = bfns_pkg::DEF_WORD_BITS
) (
   input  wire logic [WORD_BITS-1:0]         word,
   input  wire logic                         reverse,
   output logic                              hit,
   output logic [$clog2(WORD_BITS)-1:0]      pos
);
   import bfns_pkg::*;

   localparam int WB_LG = $clog2(WORD_BITS);

   logic [WORD_BITS-1:0] rev_word;
   logic [WORD_BITS-1:0] sel_word;
   logic [WORD_BITS-1:0] low_bit;
   logic [WB_LG-1:0]     raw_pos;

   // bit reversal so one encoder serves both directions
   always_comb begin
      for (int j = 0; j < WORD_BITS; j++) begin
         rev_word[j] = word[WORD_BITS-1-j];
      end
   end

   // isolate the lowest set bit
   assign sel_word = reverse ? rev_word : word;
   assign low_bit  = sel_word & (~sel_word + {{(WORD_BITS-1){1'b0}}, 1'b1});

   // one-hot to binary
   always_comb begin
      raw_pos = '0;
      for (int j = 0; j < WORD_BITS; j++) begin
         if (low_bit[j]) begin
            raw_pos = raw_pos | WB_LG'(j);
         end
      end
   end

   assign hit = |word;
   assign pos = reverse ? ~raw_pos : raw_pos;

endmodule
`default_nettype wire
